FILE: rtl/lrtc_pkg.sv
`timescale 1ns / 1ps

package lrtc_pkg;

  // Command codes of an input word.
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_PACKET  = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_CHARGE = 2'd0;
  localparam logic [1:0] REG_PULSE  = 2'd1;
  localparam logic [1:0] REG_ERASE  = 2'd2;

  // Register reset values.
  localparam logic [15:0] CHARGE_RESET = 16'd600;
  localparam logic [7:0]  PULSE_RESET  = 8'd100;
  localparam logic [15:0] ERASE_RESET  = 16'd3000;

  // Bit of the packet status byte that flags a low transmitter battery.
  localparam int unsigned LOW_BATT_BIT = 0;

  typedef enum logic [3:0] {
    EV_NONE      = 4'd0,
    EV_LEARNED   = 4'd1,
    EV_KNOWN     = 4'd2,
    EV_ACCEPTED  = 4'd3,
    EV_UNKNOWN   = 4'd4,
    EV_IGNORED   = 4'd5,
    EV_LEARN_ON  = 4'd6,
    EV_LEARN_OFF = 4'd7,
    EV_FULL      = 4'd8,
    EV_ERASED    = 4'd9,
    EV_SWITCHED  = 4'd10,
    EV_PULSE_END = 4'd11
  } ev_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_CHARGE = 2'd1,
    PH_PULSE  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SEARCH = 2'd1,
    ST_DONE   = 2'd2
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;   // latch the accepted word and restart the search
    logic search_run;  // step the table search
    logic commit;      // update state and load the result word
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic search_done;
  } dp_status_t;

endpackage

FILE: rtl/lrtc_ram.sv
`timescale 1ns / 1ps

module lrtc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 10,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/lrtc_ctrl.sv
`timescale 1ns / 1ps

module lrtc_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  lrtc_pkg::dp_status_t   status,
  output lrtc_pkg::ctrl_cmd_t    cmd
);

  lrtc_pkg::ctrl_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  assign slot_free = !out_valid_r || out_ready;

  // State and output valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lrtc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ready;
    unique case (state_r)
      lrtc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = lrtc_pkg::ST_SEARCH;
        end
      end
      lrtc_pkg::ST_SEARCH: begin
        cmd.search_run = 1'b1;
        if (status.search_done) begin
          state_nxt = lrtc_pkg::ST_DONE;
        end
      end
      lrtc_pkg::ST_DONE: begin
        if (slot_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = lrtc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lrtc_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  // A commit never overwrites a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");

  // An accepted word always starts a search.
  a_accept_search: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == lrtc_pkg::ST_SEARCH))
    else $error("accepted word did not start a search");

  // A commit always raises the output valid.
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit did not present a result");
`endif

endmodule

FILE: rtl/lrtc_datapath.sv
`timescale 1ns / 1ps

module lrtc_datapath #(
  parameter int MAX_IDS = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lrtc_pkg::ctrl_cmd_t  cmd,
  output lrtc_pkg::dp_status_t status,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_wdata,
  input  logic [1:0]           in_cmd,
  input  logic [31:0]          in_packet_id,
  input  logic [7:0]           in_packet_status,
  input  logic                 in_radio_fault,
  input  logic [15:0]          in_press_time_ms,
  input  logic                 in_fault_present,
  output logic [3:0]           out_event_res,
  output logic                 out_light_on,
  output logic                 out_bridge_drive,
  output logic                 out_learn_active,
  output logic                 out_low_battery,
  output logic [3:0]           out_ids_stored
);

  localparam int CW = $clog2(MAX_IDS + 1);
  localparam int AW = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_IDS);

  // Configuration registers.
  logic [15:0] charge_r;
  logic [7:0]  pulse_r;
  logic [15:0] erase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      charge_r <= lrtc_pkg::CHARGE_RESET;
      pulse_r  <= lrtc_pkg::PULSE_RESET;
      erase_r  <= lrtc_pkg::ERASE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lrtc_pkg::REG_CHARGE: charge_r <= cfg_wdata;
        lrtc_pkg::REG_PULSE:  pulse_r  <= cfg_wdata[7:0];
        lrtc_pkg::REG_ERASE:  erase_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Latched input word.
  logic [1:0]  cmd_r;
  logic [31:0] id_r;
  logic        batt_r;
  logic        rfault_r;
  logic [15:0] press_r;
  logic        sfault_r;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cmd_r    <= in_cmd;
      id_r     <= in_packet_id;
      batt_r   <= in_packet_status[lrtc_pkg::LOW_BATT_BIT];
      rfault_r <= in_radio_fault;
      press_r  <= in_press_time_ms;
      sfault_r <= in_fault_present;
    end
  end

  // Controller state of the switch.
  lrtc_pkg::phase_t phase_r, phase_nxt;
  logic [15:0]      cd_r, cd_nxt;
  logic             light_r, light_nxt;
  logic             learn_r, learn_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             pend_lb_r, pend_lb_nxt;
  logic             sw_lb_r, sw_lb_nxt;
  lrtc_pkg::ev_t    ev_nxt;
  logic             tbl_we;

  // ID table search: one read issued per cycle, compared in the cycle after.
  logic [CW-1:0] srch_idx_r;
  logic          rd_pend_r;
  logic          hit_r;
  logic [31:0]   rdata;
  logic          issue;
  logic          need_search;
  logic          match;

  assign need_search = (cmd_r == lrtc_pkg::CMD_PACKET) &&
                       (phase_r == lrtc_pkg::PH_IDLE) && !rfault_r;
  assign issue       = need_search && !hit_r && (srch_idx_r < count_r);
  assign match       = rd_pend_r && (rdata == id_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srch_idx_r <= '0;
      rd_pend_r  <= 1'b0;
      hit_r      <= 1'b0;
    end else if (cmd.load_item) begin
      srch_idx_r <= '0;
      rd_pend_r  <= 1'b0;
      hit_r      <= 1'b0;
    end else if (cmd.search_run) begin
      srch_idx_r <= srch_idx_r + CW'(issue);
      rd_pend_r  <= issue;
      hit_r      <= hit_r || match;
    end
  end

  assign status.search_done = !need_search ||
                              (!rd_pend_r && (hit_r || (srch_idx_r >= count_r)));

  lrtc_ram #(
    .WIDTH (32),
    .DEPTH (MAX_IDS)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (count_r[AW-1:0]),
    .wdata (id_r),
    .raddr (srch_idx_r[AW-1:0]),
    .rdata (rdata)
  );

  // Outcome of the current word.
  always_comb begin
    logic [15:0] cd_dec;
    cd_dec      = (cd_r != 16'd0) ? (cd_r - 16'd1) : 16'd0;
    phase_nxt   = phase_r;
    cd_nxt      = cd_r;
    light_nxt   = light_r;
    learn_nxt   = learn_r;
    count_nxt   = count_r;
    pend_lb_nxt = pend_lb_r;
    sw_lb_nxt   = sw_lb_r;
    ev_nxt      = lrtc_pkg::EV_NONE;
    tbl_we      = 1'b0;
    unique case (cmd_r)
      lrtc_pkg::CMD_TICK: begin
        cd_nxt = cd_dec;
        if (cd_dec == 16'd0) begin
          if (phase_r == lrtc_pkg::PH_CHARGE) begin
            light_nxt = !light_r;
            sw_lb_nxt = pend_lb_r;
            cd_nxt    = {8'd0, pulse_r};
            phase_nxt = lrtc_pkg::PH_PULSE;
            ev_nxt    = lrtc_pkg::EV_SWITCHED;
          end else if (phase_r == lrtc_pkg::PH_PULSE) begin
            cd_nxt    = charge_r;
            phase_nxt = lrtc_pkg::PH_IDLE;
            ev_nxt    = lrtc_pkg::EV_PULSE_END;
          end
        end
      end
      lrtc_pkg::CMD_PACKET: begin
        if ((phase_r != lrtc_pkg::PH_IDLE) || rfault_r) begin
          ev_nxt = lrtc_pkg::EV_IGNORED;
        end else if (learn_r) begin
          learn_nxt = 1'b0;
          if (hit_r) begin
            ev_nxt = lrtc_pkg::EV_KNOWN;
          end else if (count_r >= MAX_C) begin
            ev_nxt = lrtc_pkg::EV_FULL;
          end else begin
            tbl_we    = cmd.commit;
            count_nxt = count_r + CW'(1);
            ev_nxt    = lrtc_pkg::EV_LEARNED;
          end
        end else if (!hit_r) begin
          ev_nxt = lrtc_pkg::EV_UNKNOWN;
        end else begin
          pend_lb_nxt = batt_r;
          phase_nxt   = lrtc_pkg::PH_CHARGE;
          ev_nxt      = lrtc_pkg::EV_ACCEPTED;
        end
      end
      lrtc_pkg::CMD_RELEASE: begin
        if (phase_r != lrtc_pkg::PH_IDLE) begin
          ev_nxt = lrtc_pkg::EV_IGNORED;
        end else if (press_r >= erase_r) begin
          count_nxt = '0;
          ev_nxt    = lrtc_pkg::EV_ERASED;
        end else if (sfault_r) begin
          ev_nxt = lrtc_pkg::EV_IGNORED;
        end else if (learn_r) begin
          learn_nxt = 1'b0;
          ev_nxt    = lrtc_pkg::EV_LEARN_OFF;
        end else if (count_r < MAX_C) begin
          learn_nxt = 1'b1;
          ev_nxt    = lrtc_pkg::EV_LEARN_ON;
        end else begin
          ev_nxt = lrtc_pkg::EV_FULL;
        end
      end
      default: begin
        ev_nxt = lrtc_pkg::EV_NONE;
      end
    endcase
  end

  // State registers, updated when the word commits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= lrtc_pkg::PH_IDLE;
      cd_r      <= lrtc_pkg::CHARGE_RESET;
      light_r   <= 1'b0;
      learn_r   <= 1'b0;
      count_r   <= '0;
      pend_lb_r <= 1'b0;
      sw_lb_r   <= 1'b0;
    end else if (cmd.commit) begin
      phase_r   <= phase_nxt;
      cd_r      <= cd_nxt;
      light_r   <= light_nxt;
      learn_r   <= learn_nxt;
      count_r   <= count_nxt;
      pend_lb_r <= pend_lb_nxt;
      sw_lb_r   <= sw_lb_nxt;
    end
  end

  // Result word registers.
  logic [7:0] count_ext;
  assign count_ext = 8'(count_nxt);

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_event_res    <= ev_nxt;
      out_light_on     <= light_nxt;
      out_bridge_drive <= (phase_nxt == lrtc_pkg::PH_PULSE);
      out_learn_active <= learn_nxt;
      out_low_battery  <= sw_lb_nxt;
      out_ids_stored   <= count_ext[3:0];
    end
  end

`ifndef SYNTHESIS
  // Learn mode is only ever on while no switch is in progress.
  a_learn_idle: assert property (@(posedge clk) disable iff (!rst_n)
    learn_r |-> (phase_r == lrtc_pkg::PH_IDLE))
    else $error("learn mode active outside idle phase");

  // The search never runs past the learned entries.
  a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
    srch_idx_r <= count_r)
    else $error("search index beyond table fill");

  // A table write adds exactly one entry.
  a_learn_count: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_we |=> (count_r == $past(count_r) + CW'(1)))
    else $error("table write did not advance the count");

  // The fill never exceeds the table depth.
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_C)
    else $error("table count above depth");
`endif

endmodule

FILE: rtl/learning_remote_toggle_controller_top.sv
`timescale 1ns / 1ps

// Each word is accepted in the idle state, then runs through the search state, where a packet
// is compared against up to MAX_IDS learned IDs, one table read at a time through the single
// read port of the table memory, stopping early on a hit; it commits in the done state once
// the result slot is free. A new word is taken only after the last one has committed.
// Reset: synchronous, active low; control, configuration and switch state registers return to
// their reset values, the ID count clears and the table memory contents are left as they
// are.
module learning_remote_toggle_controller_top #(
  parameter int MAX_IDS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_packet_id,
  input  logic [7:0]  in_packet_status,
  input  logic        in_radio_fault,
  input  logic [15:0] in_press_time_ms,
  input  logic        in_fault_present,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_event_res,
  output logic        out_light_on,
  output logic        out_bridge_drive,
  output logic        out_learn_active,
  output logic        out_low_battery,
  output logic [3:0]  out_ids_stored,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  lrtc_pkg::ctrl_cmd_t  cmd;
  lrtc_pkg::dp_status_t status;

  // Sequencer for one word at a time.
  lrtc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Switch state, ID table and result registers.
  lrtc_datapath #(
    .MAX_IDS (MAX_IDS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_cmd           (in_cmd),
    .in_packet_id     (in_packet_id),
    .in_packet_status (in_packet_status),
    .in_radio_fault   (in_radio_fault),
    .in_press_time_ms (in_press_time_ms),
    .in_fault_present (in_fault_present),
    .out_event_res    (out_event_res),
    .out_light_on     (out_light_on),
    .out_bridge_drive (out_bridge_drive),
    .out_learn_active (out_learn_active),
    .out_low_battery  (out_low_battery),
    .out_ids_stored   (out_ids_stored)
  );

endmodule

FILE: bench/tb_learning_remote_toggle_controller_top.sv
`timescale 1ns / 1ps

module tb_learning_remote_toggle_controller_top;

  localparam int TABLE_DEPTH = 10;
  localparam int POOL_SIZE = 16;
  localparam int ERR_PRINT_MAX = 50;
  localparam int PHASE_WORDS = 24;
  // The fourth command code is unused by the block and must give no event.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // One status word as the block reports it.
  typedef struct packed {
    lrtc_pkg::ev_t ev;
    logic          light;
    logic          bridge;
    logic          learn;
    logic          low_batt;
    logic [3:0]    n_ids;
  } report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_cmd = lrtc_pkg::CMD_TICK;
  logic [31:0] in_packet_id = '0;
  logic [7:0]  in_packet_status = '0;
  logic        in_radio_fault = 1'b0;
  logic [15:0] in_press_time_ms = '0;
  logic        in_fault_present = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_event_res;
  logic        out_light_on;
  logic        out_bridge_drive;
  logic        out_learn_active;
  logic        out_low_battery;
  logic [3:0]  out_ids_stored;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = lrtc_pkg::REG_CHARGE;
  logic [15:0] cfg_wdata = '0;

  learning_remote_toggle_controller_top #(
    .MAX_IDS(TABLE_DEPTH)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_packet_id     (in_packet_id),
    .in_packet_status (in_packet_status),
    .in_radio_fault   (in_radio_fault),
    .in_press_time_ms (in_press_time_ms),
    .in_fault_present (in_fault_present),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_res    (out_event_res),
    .out_light_on     (out_light_on),
    .out_bridge_drive (out_bridge_drive),
    .out_learn_active (out_learn_active),
    .out_low_battery  (out_low_battery),
    .out_ids_stored   (out_ids_stored),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // Timing registers as the bench believes them to be.
  logic [15:0] cf_charge = lrtc_pkg::CHARGE_RESET;
  logic [7:0]  cf_pulse = lrtc_pkg::PULSE_RESET;
  logic [15:0] cf_erase = lrtc_pkg::ERASE_RESET;

  // Controller state as the bench tracks it.
  lrtc_pkg::phase_t m_phase = lrtc_pkg::PH_IDLE;
  logic [15:0]      m_count = lrtc_pkg::CHARGE_RESET;
  logic             m_light = 1'b0;
  logic             m_learn = 1'b0;
  logic [31:0]      m_ids[TABLE_DEPTH];
  logic [3:0]       m_n_ids = '0;
  logic             m_pend_lb = 1'b0;
  logic             m_sw_lb = 1'b0;

  report_t     reports_due[$];
  int          n_err = 0;
  bit          gaps_on = 1'b1;
  int unsigned ready_hold = 0;
  logic [31:0] id_pool[POOL_SIZE];

  always #1 clk = ~clk;

  // Run limit, far beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // The result side stalls in bursts of random length while gaps are enabled.
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      out_ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 9) == 0) begin
      ready_hold <= $urandom_range(0, 15);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare every accepted result word against the oldest expected one.
  always @(posedge clk) begin : check_reports
    report_t got;
    report_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_event_res, out_light_on, out_bridge_drive, out_learn_active,
             out_low_battery, out_ids_stored};
      if (reports_due.size() == 0) begin
        n_err++;
        if (n_err <= ERR_PRINT_MAX)
          $display("%0t: unexpected word: ev=%0d light=%0b bridge=%0b learn=%0b lb=%0b ids=%0d",
                   $time, got.ev, got.light, got.bridge, got.learn, got.low_batt, got.n_ids);
      end else begin
        want = reports_due.pop_front();
        if (got !== want) begin
          n_err++;
          if (n_err <= ERR_PRINT_MAX)
            $display({"%0t: mismatch: expected ev=%0d light=%0b bridge=%0b learn=%0b lb=%0b",
                      " ids=%0d, actual ev=%0d light=%0b bridge=%0b learn=%0b lb=%0b ids=%0d"},
                     $time, want.ev, want.light, want.bridge, want.learn, want.low_batt,
                     want.n_ids, got.ev, got.light, got.bridge, got.learn, got.low_batt,
                     got.n_ids);
        end
      end
    end
  end

  function automatic logic id_learned(input logic [31:0] id);
    for (int i = 0; i < m_n_ids; i++) begin
      if (m_ids[i] == id) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the tracked controller by one input word and return its status word.
  function automatic report_t predict_report(input logic [1:0] cmd, input logic [31:0] id,
                                             input logic [7:0] status, input logic rf,
                                             input logic [15:0] press, input logic sf);
    lrtc_pkg::ev_t ev;
    report_t       rep;
    ev = lrtc_pkg::EV_NONE;
    unique case (cmd)
      lrtc_pkg::CMD_TICK: begin
        // The countdown holds at zero; reaching zero ends a charge or pulse phase.
        if (m_count != 16'd0) m_count = m_count - 16'd1;
        if (m_count == 16'd0 && m_phase == lrtc_pkg::PH_CHARGE) begin
          m_light = ~m_light;
          m_sw_lb = m_pend_lb;
          m_count = {8'd0, cf_pulse};
          m_phase = lrtc_pkg::PH_PULSE;
          ev = lrtc_pkg::EV_SWITCHED;
        end else if (m_count == 16'd0 && m_phase == lrtc_pkg::PH_PULSE) begin
          m_count = cf_charge;
          m_phase = lrtc_pkg::PH_IDLE;
          ev = lrtc_pkg::EV_PULSE_END;
        end
      end
      lrtc_pkg::CMD_PACKET: begin
        if (m_phase != lrtc_pkg::PH_IDLE || rf) begin
          ev = lrtc_pkg::EV_IGNORED;
        end else if (m_learn) begin
          // Any good packet ends learn mode, whether or not it is stored.
          m_learn = 1'b0;
          if (id_learned(id)) begin
            ev = lrtc_pkg::EV_KNOWN;
          end else if (m_n_ids >= TABLE_DEPTH) begin
            ev = lrtc_pkg::EV_FULL;
          end else begin
            m_ids[m_n_ids] = id;
            m_n_ids = m_n_ids + 4'd1;
            ev = lrtc_pkg::EV_LEARNED;
          end
        end else if (!id_learned(id)) begin
          ev = lrtc_pkg::EV_UNKNOWN;
        end else begin
          m_pend_lb = status[lrtc_pkg::LOW_BATT_BIT];
          m_phase = lrtc_pkg::PH_CHARGE;
          ev = lrtc_pkg::EV_ACCEPTED;
        end
      end
      lrtc_pkg::CMD_RELEASE: begin
        // A long press erases even with a fault present; learn mode is kept.
        if (m_phase != lrtc_pkg::PH_IDLE) begin
          ev = lrtc_pkg::EV_IGNORED;
        end else if (press >= cf_erase) begin
          m_n_ids = '0;
          ev = lrtc_pkg::EV_ERASED;
        end else if (sf) begin
          ev = lrtc_pkg::EV_IGNORED;
        end else if (m_learn) begin
          m_learn = 1'b0;
          ev = lrtc_pkg::EV_LEARN_OFF;
        end else if (m_n_ids < TABLE_DEPTH) begin
          m_learn = 1'b1;
          ev = lrtc_pkg::EV_LEARN_ON;
        end else begin
          ev = lrtc_pkg::EV_FULL;
        end
      end
      default: ev = lrtc_pkg::EV_NONE;
    endcase
    rep.ev = ev;
    rep.light = m_light;
    rep.bridge = (m_phase == lrtc_pkg::PH_PULSE);
    rep.learn = m_learn;
    rep.low_batt = m_sw_lb;
    rep.n_ids = m_n_ids;
    return rep;
  endfunction

  // Offer one word, hold it until accepted, then record its expected status.
  // Valid is left high so that a following word can go out back to back.
  task automatic send_word(input logic [1:0] cmd, input logic [31:0] id,
                           input logic [7:0] status, input logic rf,
                           input logic [15:0] press, input logic sf);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_packet_id <= id;
    in_packet_status <= status;
    in_radio_fault <= rf;
    in_press_time_ms <= press;
    in_fault_present <= sf;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    reports_due.push_back(predict_report(cmd, id, status, rf, press, sf));
  endtask

  task automatic send_tick();
    send_word(lrtc_pkg::CMD_TICK, $urandom, 8'($urandom), 1'($urandom), 16'($urandom),
              1'($urandom));
  endtask

  task automatic send_packet(input logic [31:0] id, input logic [7:0] status, input logic rf);
    send_word(lrtc_pkg::CMD_PACKET, id, status, rf, 16'($urandom), 1'($urandom));
  endtask

  task automatic send_release(input logic [15:0] press, input logic sf);
    send_word(lrtc_pkg::CMD_RELEASE, $urandom, 8'($urandom), 1'($urandom), press, sf);
  endtask

  task automatic send_unused();
    send_word(CMD_UNUSED, $urandom, 8'($urandom), 1'($urandom), 16'($urandom),
              1'($urandom));
  endtask

  // Stop sending and wait until every expected word has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Load all three timing registers while the block is idle.
  task automatic write_timings(input logic [15:0] charge, input logic [7:0] pulse,
                               input logic [15:0] erase);
    logic [7:0] junk;
    junk = 8'($urandom);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= lrtc_pkg::REG_CHARGE;
    cfg_wdata <= charge;
    @(posedge clk);
    // Bits above the pulse register width must be dropped.
    cfg_index <= lrtc_pkg::REG_PULSE;
    cfg_wdata <= {junk, pulse};
    @(posedge clk);
    cfg_index <= lrtc_pkg::REG_ERASE;
    cfg_wdata <= erase;
    @(posedge clk);
    cfg_we <= 1'b0;
    cf_charge = charge;
    cf_pulse = pulse;
    cf_erase = erase;
  endtask

  // Tick until the switching cycle is over, and optionally until the countdown is empty.
  task automatic tick_until_idle(input bit to_zero);
    while (m_phase != lrtc_pkg::PH_IDLE || (to_zero && m_count != 16'd0)) send_tick();
  endtask

  // Reset timing: unused command, faults, the default erase threshold.
  task automatic test_reset_defaults();
    send_unused();
    send_tick();
    send_packet(id_pool[0], 8'hFF, 1'b0);
    send_packet(id_pool[1], 8'h00, 1'b1);
    send_release(16'd2999, 1'b1);
    send_release(16'd2999, 1'b0);
    send_release(16'd0, 1'b0);
    send_release(16'd3000, 1'b0);
    send_release(16'hFFFF, 1'b1);
  endtask

  // Learn IDs up to a full table, relearn a known one, then erase.
  task automatic test_learning();
    send_release(16'd0, 1'b0);
    send_packet(id_pool[0], 8'($urandom), 1'b0);
    send_release(16'd0, 1'b0);
    send_packet(id_pool[0], 8'($urandom), 1'b0);
    for (int i = 1; i < TABLE_DEPTH; i++) begin
      send_release(16'($urandom_range(0, 2999)), 1'b0);
      send_packet(id_pool[i], 8'($urandom), 1'b0);
    end
    send_release(16'd0, 1'b0);
    send_packet(id_pool[POOL_SIZE - 1], 8'($urandom), 1'b0);
    send_release(16'd3000, 1'b1);
    // A faulty packet in learn mode is dropped and learn mode stays on.
    send_release(16'd1, 1'b0);
    send_packet(id_pool[3], 8'($urandom), 1'b1);
    send_packet(id_pool[3], 8'($urandom), 1'b0);
    send_release(16'd1, 1'b0);
    send_packet(id_pool[4], 8'($urandom), 1'b0);
  endtask

  // A known ID waits for the charge, switches, pulses; words meanwhile are ignored.
  task automatic test_busy_and_switching();
    write_timings(16'd4, 8'd2, lrtc_pkg::ERASE_RESET);
    tick_until_idle(1'b1);
    send_packet(id_pool[3], 8'h01, 1'b0);
    send_packet(id_pool[3], 8'h00, 1'b0);
    send_release(16'd100, 1'b0);
    send_tick();
    send_release(16'hFFFF, 1'b0);
    tick_until_idle(1'b0);
    send_packet(id_pool[4], 8'hFE, 1'b0);
    tick_until_idle(1'b0);
  endtask

  // With zero times each phase ends on the very next tick; every release in the idle phase erases.
  task automatic test_zero_times();
    write_timings(16'd0, 8'd0, 16'd0);
    tick_until_idle(1'b1);
    send_packet(id_pool[3], 8'h01, 1'b0);
    send_tick();
    send_tick();
    send_packet(id_pool[4], 8'h00, 1'b0);
    send_tick();
    tick_until_idle(1'b1);
    send_release(16'd0, 1'b1);
  endtask

  // Mixed traffic over several timing settings, mostly ticks and pool IDs.
  task automatic test_random_traffic();
    int          r;
    int          pick;
    logic [15:0] erase;
    logic [15:0] press;
    logic [31:0] id;
    for (int p = 0; p < 5; p++) begin
      unique case (p % 3)
        0: erase = 16'($urandom_range(1, 16'hFFFF));
        1: erase = 16'($urandom_range(0, 40));
        default: erase = lrtc_pkg::ERASE_RESET;
      endcase
      write_timings(16'($urandom_range(0, 12)), 8'($urandom_range(0, 8)), erase);
      gaps_on = (p != 2 && p != 4);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          send_tick();
        end else if (r < 75) begin
          id = ($urandom_range(0, 9) < 7) ? id_pool[$urandom_range(0, POOL_SIZE - 1)]
                                          : $urandom;
          send_packet(id, 8'($urandom), $urandom_range(0, 9) == 0);
        end else if (r < 93) begin
          // Mostly presses on either side of the erase threshold.
          pick = $urandom_range(0, 9);
          if (pick < 6 && cf_erase != 0)
            press = 16'($urandom_range(0, cf_erase - 1));
          else if (pick < 8)
            press = 16'($urandom_range(cf_erase, 16'hFFFF));
          else
            press = 16'($urandom);
          send_release(press, $urandom_range(0, 7) == 0);
        end else begin
          send_unused();
        end
        if ($urandom_range(0, 59) == 0) wait_idle();
      end
    end
  endtask

  // Largest timing values: erase only at a full-scale press, a 255-tick pulse.
  task automatic test_extreme_times();
    tick_until_idle(1'b1);
    write_timings(16'hFFFF, 8'hFF, 16'hFFFF);
    if (m_learn) send_release(16'd0, 1'b0);
    send_release(16'hFFFF, 1'b0);
    send_release(16'hFFFE, 1'b0);
    send_packet(id_pool[5], 8'h01, 1'b0);
    send_packet(id_pool[5], 8'h81, 1'b0);
    send_tick();
    repeat (8) send_tick();
    send_packet(id_pool[5], 8'h00, 1'b0);
    send_release(16'hFFFF, 1'b0);
  endtask

  // Main sequence.
  initial begin
    for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = $urandom;
    id_pool[0] = '0;
    id_pool[1] = '1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_learning();
    test_busy_and_switching();
    test_zero_times();
    test_random_traffic();
    test_extreme_times();
    wait_idle();
    repeat (20) @(posedge clk);
    if (n_err == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: sim.f
rtl/lrtc_pkg.sv
rtl/lrtc_ram.sv
rtl/lrtc_ctrl.sv
rtl/lrtc_datapath.sv
rtl/learning_remote_toggle_controller_top.sv
bench/tb_learning_remote_toggle_controller_top.sv
